// ===== hw/rtl/ertt_pkg.sv =====
// Package for the echo request timeout tracker.
// Holds item layouts, operation and status codes, register indexes and FSM states.
// No dependencies.
package ertt_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MS     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ADDRESS = 1'd1;

  localparam logic [15:0] TIMEOUT_MS_RESET     = 16'd2500;
  localparam logic [31:0] TARGET_ADDRESS_RESET = 32'h0808_0808;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // send status codes
  localparam logic [1:0] SEND_OK        = 2'd0;
  localparam logic [1:0] SEND_NO_DEVICE = 2'd1;

  // latest status codes
  localparam logic [1:0] STATUS_WAITING  = 2'd0;
  localparam logic [1:0] STATUS_REPLY    = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;
  localparam logic [1:0] STATUS_SEND_ERR = 2'd3;

  localparam logic [4:0] RETIRED_MAX = 5'd31;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] now_ms;
    logic [1:0]  send_status;
    logic [31:0] reply_source;
    logic [15:0] reply_seq;
    logic [47:0] reply_delay_us;
  } req_t;

  typedef struct packed {
    logic [15:0] assigned_sequence;
    logic        reply_matched;
    logic        reply_accepted;
    logic [4:0]  timeouts_now;
    logic [1:0]  latest_status;
    logic [31:0] sent_total;
    logic [31:0] received_total;
    logic [31:0] timed_out_total;
    logic [63:0] delay_sum_us;
    logic [31:0] latest_delay_us;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_REM,
    S_READ,
    S_MATCH,
    S_SCAN,
    S_SCAN_TAIL,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/ertt_stream.sv =====
// Valid/ready stream interface used for request and result beats.
// Payload type is set per instance; depends on nothing else.
interface ertt_stream #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/echo_request_timeout_tracker.sv =====
// Channel   Dir  Handshake    Beat
// req       in   valid/ready  ertt_pkg::req_t, one echo event (tick, send or reply)
// rsp       out  valid/ready  ertt_pkg::rsp_t, one result per request beat
// cfg       in   cfg_we       cfg_index selects timeout_ms or target_address
//
// One request at a time. Send: a send step, then finish. Reply from the target: the
// two-step sequence remainder, the slot table read and the match step, then finish. Tick:
// a scan, one slot age compare per cycle through the shared 48-bit subtractor, a tail
// step and finish. Other beats go to finish. rst is synchronous; the slot table needs no
// clearing pass. A stalled result holds in the output register; the next beat still runs
// and then waits at its finish step, req.ready low, until the register frees.
module echo_request_timeout_tracker #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ertt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ertt_pkg::CFG_DATA_W-1:0]   cfg_data,
  ertt_stream.sink                          req,
  ertt_stream.source                        rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  // reciprocal of SLOTS, exact for every 16-bit sequence
  localparam int RECIP_SHIFT = 16 + IDX_W;
  localparam logic [17:0] RECIP =
    18'(((64'd1 << RECIP_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  ertt_pkg::state_t state, state_next;

  // configuration
  logic [15:0] timeout_ms;
  logic [31:0] target_address;

  // slot table
  logic [SLOTS-1:0] slot_valid;
  logic [15:0]      mem_seq  [SLOTS];
  logic [47:0]      mem_time [SLOTS];
  logic [15:0]      rd_seq;
  logic [47:0]      rd_time;

  // tracker state
  logic [15:0]      next_sequence;
  logic [IDX_W-1:0] send_slot;
  logic [31:0]      sent_count;
  logic [31:0]      rx_count;
  logic [31:0]      expired_count;
  logic [63:0]      delay_sum;
  logic [31:0]      last_delay;
  logic [1:0]       last_status;

  // item and per-item results
  logic [47:0] now_q;
  logic [1:0]  status_q;
  logic [15:0] rseq_q;
  logic [15:0] res_assigned;
  logic        res_matched;
  logic        res_accepted;
  logic [4:0]  res_retired;

  // sequencer registers
  logic [IDX_W-1:0] rem;
  logic             rem_step;
  logic [15:0]      quot_q;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] eval_idx;
  logic             eval_en;

  logic             out_valid;
  ertt_pkg::rsp_t   out_data;

  // control outputs
  logic             req_fire;
  logic             out_load;
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;

  // datapath
  logic [33:0]      recip_prod;
  logic [15:0]      quot_calc;
  logic [24:0]      quot_mul;
  logic [24:0]      rem_full;
  logic [IDX_W-1:0] rem_calc;
  logic [47:0]      age;
  logic             timed_out;
  logic             src_hit;
  logic [31:0]      delay_sat;

  assign req_fire  = req.valid && req.ready;
  assign src_hit   = req.data.reply_source == target_address;
  assign delay_sat = (|req.data.reply_delay_us[47:32]) ? 32'hFFFF_FFFF
                                                        : req.data.reply_delay_us[31:0];

  // sequence modulo SLOTS: quotient by reciprocal multiply, remainder the next cycle
  assign recip_prod = 34'(rseq_q) * 34'(RECIP);
  assign quot_calc  = 16'(recip_prod >> RECIP_SHIFT);
  assign quot_mul   = 25'(quot_q) * 25'(SLOTS);
  assign rem_full   = 25'(rseq_q) - quot_mul;
  assign rem_calc   = rem_full[IDX_W-1:0];

  // shared age unit for the tick scan
  assign age       = now_q - rd_time;
  assign timed_out = eval_en && slot_valid[eval_idx] && (age >= {32'd0, timeout_ms});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ertt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ertt_pkg::S_IDLE: begin
        if (req_fire) begin
          case (req.data.op)
            ertt_pkg::OP_TICK:  state_next = ertt_pkg::S_SCAN;
            ertt_pkg::OP_SEND:  state_next = ertt_pkg::S_SEND;
            ertt_pkg::OP_REPLY: state_next = src_hit ? ertt_pkg::S_REM : ertt_pkg::S_FINISH;
            default:            state_next = ertt_pkg::S_FINISH;
          endcase
        end
      end
      ertt_pkg::S_SEND:      state_next = ertt_pkg::S_FINISH;
      ertt_pkg::S_REM:       if (!rem_step) state_next = ertt_pkg::S_READ;
      ertt_pkg::S_READ:      state_next = ertt_pkg::S_MATCH;
      ertt_pkg::S_MATCH:     state_next = ertt_pkg::S_FINISH;
      ertt_pkg::S_SCAN:      if (scan_idx == LAST_IDX) state_next = ertt_pkg::S_SCAN_TAIL;
      ertt_pkg::S_SCAN_TAIL: state_next = ertt_pkg::S_FINISH;
      ertt_pkg::S_FINISH:    if (out_load) state_next = ertt_pkg::S_IDLE;
      default:               state_next = ertt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = rem;
    unique case (state)
      ertt_pkg::S_IDLE:   req.ready = 1'b1;
      ertt_pkg::S_SEND:   mem_we    = status_q != ertt_pkg::SEND_NO_DEVICE;
      ertt_pkg::S_SCAN:   rd_addr   = scan_idx;
      ertt_pkg::S_FINISH: out_load  = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  // slot table storage, one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_seq[send_slot]  <= next_sequence;
      mem_time[send_slot] <= now_q;
    end
    rd_seq  <= mem_seq[rd_addr];
    rd_time <= mem_time[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms     <= ertt_pkg::TIMEOUT_MS_RESET;
      target_address <= ertt_pkg::TARGET_ADDRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ertt_pkg::REG_TIMEOUT_MS:     timeout_ms     <= cfg_data[15:0];
        ertt_pkg::REG_TARGET_ADDRESS: target_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      next_sequence <= '0;
      send_slot     <= '0;
      sent_count    <= '0;
      rx_count      <= '0;
      expired_count <= '0;
      delay_sum     <= '0;
      last_delay    <= '0;
      last_status   <= ertt_pkg::STATUS_WAITING;
      eval_en       <= 1'b0;
    end else begin
      unique case (state) inside
        ertt_pkg::S_IDLE: begin
          eval_en <= 1'b0;
          if (req_fire && req.data.op == ertt_pkg::OP_REPLY && src_hit) begin
            rx_count    <= rx_count + 32'd1;
            delay_sum   <= delay_sum + {32'd0, delay_sat};
            last_delay  <= delay_sat;
            last_status <= ertt_pkg::STATUS_REPLY;
          end
        end
        ertt_pkg::S_SEND: begin
          next_sequence <= next_sequence + 16'd1;
          // slot index follows sequence modulo SLOTS, restarting when the sequence wraps
          if (next_sequence == 16'hFFFF || send_slot == LAST_IDX) begin
            send_slot <= '0;
          end else begin
            send_slot <= send_slot + IDX_W'(1);
          end
          if (status_q == ertt_pkg::SEND_OK) begin
            slot_valid[send_slot] <= 1'b1;
            sent_count            <= sent_count + 32'd1;
          end else begin
            last_status <= ertt_pkg::STATUS_SEND_ERR;
            if (status_q != ertt_pkg::SEND_NO_DEVICE) slot_valid[send_slot] <= 1'b0;
          end
        end
        ertt_pkg::S_MATCH: begin
          if (slot_valid[rem] && rd_seq == rseq_q) slot_valid[rem] <= 1'b0;
        end
        ertt_pkg::S_SCAN, ertt_pkg::S_SCAN_TAIL: begin
          eval_en <= state == ertt_pkg::S_SCAN;
          if (timed_out) begin
            slot_valid[eval_idx] <= 1'b0;
            expired_count        <= expired_count + 32'd1;
            last_status          <= ertt_pkg::STATUS_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
  end

  // item payload and sequencer counters
  always_ff @(posedge clk) begin
    unique case (state) inside
      ertt_pkg::S_IDLE: begin
        if (req_fire) begin
          now_q        <= req.data.now_ms;
          status_q     <= req.data.send_status;
          rseq_q       <= req.data.reply_seq;
          res_assigned <= '0;
          res_matched  <= 1'b0;
          res_accepted <= req.data.op == ertt_pkg::OP_REPLY && src_hit;
          res_retired  <= '0;
          rem          <= '0;
          rem_step     <= 1'b1;
          scan_idx     <= '0;
        end
      end
      ertt_pkg::S_SEND: res_assigned <= next_sequence;
      ertt_pkg::S_REM: begin
        rem_step <= 1'b0;
        if (rem_step) begin
          quot_q <= quot_calc;
        end else begin
          rem <= rem_calc;
        end
      end
      ertt_pkg::S_MATCH: res_matched <= slot_valid[rem] && rd_seq == rseq_q;
      ertt_pkg::S_SCAN, ertt_pkg::S_SCAN_TAIL: begin
        eval_idx <= scan_idx;
        scan_idx <= scan_idx + IDX_W'(1);
        if (timed_out && res_retired != ertt_pkg::RETIRED_MAX) begin
          res_retired <= res_retired + 5'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.assigned_sequence <= res_assigned;
      out_data.reply_matched     <= res_matched;
      out_data.reply_accepted    <= res_accepted;
      out_data.timeouts_now      <= res_retired;
      out_data.latest_status     <= last_status;
      out_data.sent_total        <= sent_count;
      out_data.received_total    <= rx_count;
      out_data.timed_out_total   <= expired_count;
      out_data.delay_sum_us      <= delay_sum;
      out_data.latest_delay_us   <= last_delay;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

// ===== hw/rtl/ertt_checker.sv =====
// Port-level checks for the echo request timeout tracker.
// Depends on ertt_pkg; bound to echo_request_timeout_tracker below.
module ertt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        matched,
  input logic        accepted,
  input logic [4:0]  timeouts_now,
  input logic [1:0]  latest_status
);

  // a request beat makes the block busy for at least the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("req ready right after an accepted beat");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

  // a match can only come from an accepted reply
  a_match_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && matched) |-> accepted)
    else $error("reply matched without being accepted");

  // retirements leave the timeout status behind
  a_timeout_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && timeouts_now != 5'd0) |-> latest_status == ertt_pkg::STATUS_TIMEOUT)
    else $error("timeouts reported without timeout status");

endmodule

bind echo_request_timeout_tracker ertt_checker u_ertt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .matched       (rsp.data.reply_matched),
  .accepted      (rsp.data.reply_accepted),
  .timeouts_now  (rsp.data.timeouts_now),
  .latest_status (rsp.data.latest_status)
);

// ===== sim/tb_echo_request_timeout_tracker.sv =====
// Testbench for echo_request_timeout_tracker: directed and random echo events.
// A local model of the slot table predicts every result beat for comparison.
// Depends on ertt_pkg, ertt_stream and the tracker RTL.
`timescale 1ns / 1ps

module tb_echo_request_timeout_tracker;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 50;

  localparam logic [1:0] SEND_FAILED = 2'd2;
  localparam logic [1:0] SEND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ertt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ertt_pkg::CFG_DATA_W-1:0] cfg_data;

  ertt_stream #(.T(ertt_pkg::req_t)) req_if ();
  ertt_stream #(.T(ertt_pkg::rsp_t)) rsp_if ();

  echo_request_timeout_tracker #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #5 clk = ~clk;

  // tracker model state
  logic        slot_live [SLOTS];
  logic [15:0] slot_seq  [SLOTS];
  logic [47:0] slot_time [SLOTS];
  logic [15:0] next_seq;
  logic [31:0] sent_cnt;
  logic [31:0] recv_cnt;
  logic [31:0] expired_cnt;
  logic [63:0] delay_total;
  logic [31:0] last_delay;
  logic [1:0]  last_status;
  logic [15:0] age_limit_ms;
  logic [31:0] accept_addr;

  ertt_pkg::rsp_t tracker_results_due [$];
  int             errors = 0;
  int unsigned    quiet_cycles = 0;
  bit             steady = 1'b0;
  logic [47:0]    clock_ms;

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic int pause_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ertt_pkg::req_t make_beat(logic [1:0] op, logic [47:0] now,
                                               logic [1:0] status, logic [31:0] src,
                                               logic [15:0] seq, logic [47:0] delay);
    ertt_pkg::req_t b;
    b.op = op;
    b.now_ms = now;
    b.send_status = status;
    b.reply_source = src;
    b.reply_seq = seq;
    b.reply_delay_us = delay;
    return b;
  endfunction

  // Apply one event to the model and return the result beat it owes.
  function automatic ertt_pkg::rsp_t track_echo_event(ertt_pkg::req_t b);
    ertt_pkg::rsp_t r;
    logic [47:0] age;
    logic [31:0] d;
    int idx;
    r = '0;
    case (b.op)
      ertt_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          age = b.now_ms - slot_time[i];
          if (slot_live[i] && age >= {32'd0, age_limit_ms}) begin
            slot_live[i] = 1'b0;
            expired_cnt++;
            last_status = ertt_pkg::STATUS_TIMEOUT;
            if (r.timeouts_now != ertt_pkg::RETIRED_MAX) r.timeouts_now++;
          end
        end
      end
      ertt_pkg::OP_SEND: begin
        r.assigned_sequence = next_seq;
        idx = next_seq % SLOTS;
        if (b.send_status == ertt_pkg::SEND_NO_DEVICE) begin
          last_status = ertt_pkg::STATUS_SEND_ERR;
        end else begin
          slot_seq[idx] = next_seq;
          slot_time[idx] = b.now_ms;
          if (b.send_status == ertt_pkg::SEND_OK) begin
            slot_live[idx] = 1'b1;
            sent_cnt++;
          end else begin
            slot_live[idx] = 1'b0;
            last_status = ertt_pkg::STATUS_SEND_ERR;
          end
        end
        next_seq++;
      end
      ertt_pkg::OP_REPLY: begin
        if (b.reply_source == accept_addr) begin
          d = (b.reply_delay_us > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : b.reply_delay_us[31:0];
          idx = b.reply_seq % SLOTS;
          r.reply_accepted = 1'b1;
          if (slot_live[idx] && slot_seq[idx] == b.reply_seq) begin
            slot_live[idx] = 1'b0;
            r.reply_matched = 1'b1;
          end
          recv_cnt++;
          delay_total += {32'd0, d};
          last_delay = d;
          last_status = ertt_pkg::STATUS_REPLY;
        end
      end
      default: ;
    endcase
    r.latest_status = last_status;
    r.sent_total = sent_cnt;
    r.received_total = recv_cnt;
    r.timed_out_total = expired_cnt;
    r.delay_sum_us = delay_total;
    r.latest_delay_us = last_delay;
    return r;
  endfunction

  task automatic report(string msg);
    if (errors < MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(ertt_pkg::req_t beat);
    repeat (pause_len()) @(negedge clk);
    req_if.data = beat;
    req_if.valid = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    tracker_results_due.push_back(track_echo_event(beat));
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic write_reg(logic [ertt_pkg::CFG_INDEX_W-1:0] idx,
                           logic [ertt_pkg::CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == ertt_pkg::REG_TIMEOUT_MS) age_limit_ms = value[15:0];
    else accept_addr = value;
  endtask

  task automatic wait_drain();
    while (tracker_results_due.size() != 0) @(negedge clk);
  endtask

  // Result beats: compare against the oldest expectation.
  always @(posedge clk) begin : check_results
    ertt_pkg::rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (tracker_results_due.size() == 0) begin
        report("result beat with no expectation waiting");
      end else begin
        want = tracker_results_due.pop_front();
        check_field("assigned_sequence", 64'(rsp_if.data.assigned_sequence),
                    64'(want.assigned_sequence));
        check_field("reply_matched", 64'(rsp_if.data.reply_matched),
                    64'(want.reply_matched));
        check_field("reply_accepted", 64'(rsp_if.data.reply_accepted),
                    64'(want.reply_accepted));
        check_field("timeouts_now", 64'(rsp_if.data.timeouts_now),
                    64'(want.timeouts_now));
        check_field("latest_status", 64'(rsp_if.data.latest_status),
                    64'(want.latest_status));
        check_field("sent_total", 64'(rsp_if.data.sent_total), 64'(want.sent_total));
        check_field("received_total", 64'(rsp_if.data.received_total),
                    64'(want.received_total));
        check_field("timed_out_total", 64'(rsp_if.data.timed_out_total),
                    64'(want.timed_out_total));
        check_field("delay_sum_us", rsp_if.data.delay_sum_us, want.delay_sum_us);
        check_field("latest_delay_us", 64'(rsp_if.data.latest_delay_us),
                    64'(want.latest_delay_us));
      end
    end
  end

  // Result side back-pressure: ready runs, then random stalls.
  initial begin : drive_rsp_ready
    int gap;
    rsp_if.ready = 1'b0;
    forever begin
      rsp_if.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      gap = pause_len();
      if (gap != 0) begin
        rsp_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_reset_defaults();
    send_beat(make_beat(ertt_pkg::OP_NONE, '1, SEND_UNUSED, '1, '1, '1));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd0, ertt_pkg::SEND_OK, '0, '0, '0));
    // reply before any send: accepted, nothing to free
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK,
                        ertt_pkg::TARGET_ADDRESS_RESET, 16'd0, 48'd0));
  endtask

  task automatic test_send_paths();
    logic [15:0] first;
    first = next_seq;
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd1000, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd1001, ertt_pkg::SEND_NO_DEVICE, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd1002, SEND_FAILED, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd1003, SEND_UNUSED, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK,
                        ~ertt_pkg::TARGET_ADDRESS_RESET, first, 48'd77));
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK,
                        ertt_pkg::TARGET_ADDRESS_RESET, first, 48'hFFFF_FFFF));
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK,
                        ertt_pkg::TARGET_ADDRESS_RESET, first + 16'd2, 48'd5));
    // delay above 32 bits saturates
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK,
                        ertt_pkg::TARGET_ADDRESS_RESET, first + 16'd1, 48'hFFFF_FFFF_FFFF));
  endtask

  task automatic test_time_wrap();
    // age straddles the 48-bit wrap; retire exactly at the limit
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'hFFFF_FFFF_FFF0, ertt_pkg::SEND_OK,
                        '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd2483, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd2484, ertt_pkg::SEND_OK, '0, '0, '0));
  endtask

  task automatic test_slot_table();
    logic [15:0] first;
    first = next_seq;
    // one extra send overwrites a live slot
    for (int i = 0; i <= SLOTS; i++) begin
      send_beat(make_beat(ertt_pkg::OP_SEND, 48'd10000, ertt_pkg::SEND_OK, '0, '0, '0));
    end
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK,
                        ertt_pkg::TARGET_ADDRESS_RESET, first, 48'd9));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd12500, ertt_pkg::SEND_OK, '0, '0, '0));
  endtask

  task automatic test_config_extremes();
    logic [15:0] s;
    wait_drain();
    write_reg(ertt_pkg::REG_TIMEOUT_MS, {16'hFFFF, 16'd0});
    write_reg(ertt_pkg::REG_TARGET_ADDRESS, 32'h0);
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd7, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd7, ertt_pkg::SEND_OK, '0, '0, '0));
    s = next_seq;
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd50, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK, 32'h0, s, 48'd5));

    wait_drain();
    write_reg(ertt_pkg::REG_TIMEOUT_MS, {16'($urandom), 16'hFFFF});
    write_reg(ertt_pkg::REG_TARGET_ADDRESS, 32'hFFFF_FFFF);
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd0, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd65534, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd65535, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK, 32'hFFFF_FFFF,
                        16'($urandom), 48'd1));
    send_beat(make_beat(ertt_pkg::OP_REPLY, 48'd0, ertt_pkg::SEND_OK, 32'h0,
                        16'($urandom), 48'd1));

    wait_drain();
    write_reg(ertt_pkg::REG_TIMEOUT_MS, {16'($urandom), 16'd1});
    write_reg(ertt_pkg::REG_TARGET_ADDRESS, ertt_pkg::TARGET_ADDRESS_RESET);
    send_beat(make_beat(ertt_pkg::OP_SEND, 48'd300, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd300, ertt_pkg::SEND_OK, '0, '0, '0));
    send_beat(make_beat(ertt_pkg::OP_TICK, 48'd301, ertt_pkg::SEND_OK, '0, '0, '0));
  endtask

  task automatic random_burst(int count);
    ertt_pkg::req_t beat;
    int pick;
    int step;
    step = age_limit_ms / 4 + 1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      beat = make_beat(ertt_pkg::OP_NONE, rand48(), 2'($urandom), $urandom,
                       16'($urandom), rand48());
      // occasional jump of the time base, often just below the wrap
      if (pick < 3) begin
        if ($urandom_range(0, 1) != 0) clock_ms = rand48();
        else clock_ms = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3 * step));
      end
      if (pick < 38) begin
        beat.op = ertt_pkg::OP_SEND;
        clock_ms += 48'($urandom_range(0, step));
        beat.now_ms = clock_ms;
        if ($urandom_range(0, 9) < 8) beat.send_status = ertt_pkg::SEND_OK;
      end else if (pick < 75) begin
        beat.op = ertt_pkg::OP_REPLY;
        if ($urandom_range(0, 9) < 8) beat.reply_source = accept_addr;
        if ($urandom_range(0, 9) < 7) beat.reply_seq = next_seq - 16'($urandom_range(1, 20));
        if ($urandom_range(0, 9) < 8) beat.reply_delay_us = 48'($urandom);
      end else if (pick < 95) begin
        beat.op = ertt_pkg::OP_TICK;
        clock_ms += 48'($urandom_range(0, 2 * step));
        beat.now_ms = clock_ms;
      end
      send_beat(beat);
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] lim;
    logic [31:0] addr;
    for (int p = 0; p < 6; p++) begin
      wait_drain();
      case (p)
        0: begin
          lim = ertt_pkg::TIMEOUT_MS_RESET;
          addr = $urandom;
        end
        1: begin
          lim = 16'd1;
          addr = 32'h0;
        end
        2: begin
          lim = 16'hFFFF;
          addr = 32'hFFFF_FFFF;
        end
        3: begin
          lim = 16'($urandom_range(1, 100));
          addr = $urandom;
        end
        default: begin
          lim = 16'($urandom_range(1, 65535));
          addr = $urandom;
        end
      endcase
      write_reg(ertt_pkg::REG_TIMEOUT_MS, {16'($urandom), lim});
      write_reg(ertt_pkg::REG_TARGET_ADDRESS, addr);
      // one phase runs with no idling on either side
      steady = (p == 3);
      clock_ms = rand48();
      random_burst(170);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_seq[i] = '0;
      slot_time[i] = '0;
    end
    next_seq = '0;
    sent_cnt = '0;
    recv_cnt = '0;
    expired_cnt = '0;
    delay_total = '0;
    last_delay = '0;
    last_status = ertt_pkg::STATUS_WAITING;
    age_limit_ms = ertt_pkg::TIMEOUT_MS_RESET;
    accept_addr = ertt_pkg::TARGET_ADDRESS_RESET;
    clock_ms = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_send_paths();
    test_time_wrap();
    test_slot_table();
    test_config_extremes();
    test_random_traffic();

    wait_drain();
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    if (tracker_results_due.size() != 0) report("expectations left over at end of run");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
